// File: sv/md5_pkg.sv
`default_nettype none
package md5_pkg;

	typedef struct packed {
		logic [7:0] byte_val;
		logic       has_byte;
		logic       is_final;
	} md5_item_t;

	typedef struct packed {
		logic      valid;
		md5_item_t item;
	} md5_queue_out_t;

	localparam logic [31:0] InitA = 32'h67452301;
	localparam logic [31:0] InitB = 32'hefcdab89;
	localparam logic [31:0] InitC = 32'h98badcfe;
	localparam logic [31:0] InitD = 32'h10325476;

	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		unique case (i)
			6'd0:  k = 32'd3614090360;
			6'd1:  k = 32'd3905402710;
			6'd2:  k = 32'd606105819;
			6'd3:  k = 32'd3250441966;
			6'd4:  k = 32'd4118548399;
			6'd5:  k = 32'd1200080426;
			6'd6:  k = 32'd2821735955;
			6'd7:  k = 32'd4249261313;
			6'd8:  k = 32'd1770035416;
			6'd9:  k = 32'd2336552879;
			6'd10: k = 32'd4294925233;
			6'd11: k = 32'd2304563134;
			6'd12: k = 32'd1804603682;
			6'd13: k = 32'd4254626195;
			6'd14: k = 32'd2792965006;
			6'd15: k = 32'd1236535329;
			6'd16: k = 32'd4129170786;
			6'd17: k = 32'd3225465664;
			6'd18: k = 32'd643717713;
			6'd19: k = 32'd3921069994;
			6'd20: k = 32'd3593408605;
			6'd21: k = 32'd38016083;
			6'd22: k = 32'd3634488961;
			6'd23: k = 32'd3889429448;
			6'd24: k = 32'd568446438;
			6'd25: k = 32'd3275163606;
			6'd26: k = 32'd4107603335;
			6'd27: k = 32'd1163531501;
			6'd28: k = 32'd2850285829;
			6'd29: k = 32'd4243563512;
			6'd30: k = 32'd1735328473;
			6'd31: k = 32'd2368359562;
			6'd32: k = 32'd4294588738;
			6'd33: k = 32'd2272392833;
			6'd34: k = 32'd1839030562;
			6'd35: k = 32'd4259657740;
			6'd36: k = 32'd2763975236;
			6'd37: k = 32'd1272893353;
			6'd38: k = 32'd4139469664;
			6'd39: k = 32'd3200236656;
			6'd40: k = 32'd681279174;
			6'd41: k = 32'd3936430074;
			6'd42: k = 32'd3572445317;
			6'd43: k = 32'd76029189;
			6'd44: k = 32'd3654602809;
			6'd45: k = 32'd3873151461;
			6'd46: k = 32'd530742520;
			6'd47: k = 32'd3299628645;
			6'd48: k = 32'd4096336452;
			6'd49: k = 32'd1126891415;
			6'd50: k = 32'd2878612391;
			6'd51: k = 32'd4237533241;
			6'd52: k = 32'd1700485571;
			6'd53: k = 32'd2399980690;
			6'd54: k = 32'd4293915773;
			6'd55: k = 32'd2240044497;
			6'd56: k = 32'd1873313359;
			6'd57: k = 32'd4264355552;
			6'd58: k = 32'd2734768916;
			6'd59: k = 32'd1309151649;
			6'd60: k = 32'd4149444226;
			6'd61: k = 32'd3174756917;
			6'd62: k = 32'd718787259;
			default: k = 32'd3951481745;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] md5_rot(input logic [5:0] i);
		logic [4:0] r;
		unique case ({i[5:4], i[1:0]})
			4'd0:  r = 5'd7;
			4'd1:  r = 5'd12;
			4'd2:  r = 5'd17;
			4'd3:  r = 5'd22;
			4'd4:  r = 5'd5;
			4'd5:  r = 5'd9;
			4'd6:  r = 5'd14;
			4'd7:  r = 5'd20;
			4'd8:  r = 5'd4;
			4'd9:  r = 5'd11;
			4'd10: r = 5'd16;
			4'd11: r = 5'd23;
			4'd12: r = 5'd6;
			4'd13: r = 5'd10;
			4'd14: r = 5'd15;
			default: r = 5'd21;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] md5_g(input logic [5:0] i);
		logic [3:0] j;
		logic [3:0] g;
		j = i[3:0];
		unique case (i[5:4])
			2'd0: g = j;
			2'd1: g = 4'(j * 4'd5 + 4'd1);
			2'd2: g = 4'(j * 4'd3 + 4'd5);
			default: g = 4'(j * 4'd7);
		endcase
		return g;
	endfunction

endpackage
`default_nettype wire

// File: sv/md5_front.sv
`default_nettype none
module md5_front import md5_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [7:0]     msg_byte,
	input  wire logic           byte_present,
	input  wire logic           final_req,
	output md5_queue_out_t      q_out,
	input  wire logic           q_pop
);

	md5_item_t  fifo_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       push;

	// Transactions with neither flag set carry nothing and are dropped here.
	assign in_ready = ~count_q[2];
	assign push     = in_valid & in_ready & (byte_present | final_req);

	assign q_out.valid = (count_q != 3'd0);
	assign q_out.item  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			if (push) begin
				fifo_q[wr_ptr_q] <= '{byte_val: msg_byte, has_byte: byte_present,
					is_final: final_req};
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (q_pop && q_out.valid) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + 3'(push) - 3'(q_pop && q_out.valid);
		end
	end

endmodule
`default_nettype wire

// File: sv/md5_back.sv
`default_nettype none
module md5_back import md5_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire md5_queue_out_t  q_out,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [31:0]          digest_word,
	output logic [1:0]           word_index,
	output logic                 last_word
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PSTART,
		ST_PAD,
		ST_COMP,
		ST_FIN,
		ST_EMIT
	} state_t;

	state_t      state_q;
	logic [31:0] chain_q [4];
	logic [63:0] bit_count_q;
	logic [31:0] acc_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0]  step_q;
	logic [3:0]  pw_q;
	logic        pad_first_q;
	logic        long_q;
	logic        second_q;
	logic        padding_q;
	logic        pend_final_q;
	logic [1:0]  emit_k_q;
	logic        out_valid_q;
	logic [31:0] digest_word_q;
	logic [1:0]  word_index_q;
	logic        last_word_q;

	logic [31:0] word_mem [16];
	logic [31:0] rdata_q;
	logic        mem_we;
	logic [3:0]  mem_waddr;
	logic [31:0] mem_wdata;
	logic [3:0]  mem_raddr;

	logic [1:0]  byte_pos;
	logic [3:0]  word_pos;
	logic [31:0] merged_word;
	logic [31:0] pad_word;
	logic [31:0] f_val;
	logic [31:0] t_sum;
	logic [4:0]  rot;
	logic [31:0] t_rot;
	logic [31:0] t_new;
	logic        out_load;

	assign byte_pos = bit_count_q[4:3];
	assign word_pos = bit_count_q[8:5];
	assign out_load = ~out_valid_q | out_ready;
	assign q_pop    = (state_q == ST_IDLE) & q_out.valid;

	assign out_valid   = out_valid_q;
	assign digest_word = digest_word_q;
	assign word_index  = word_index_q;
	assign last_word   = last_word_q;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			if (2'(j) < byte_pos) begin
				merged_word[8*j +: 8] = acc_q[8*j +: 8];
			end else if (2'(j) == byte_pos) begin
				merged_word[8*j +: 8] = 8'h80;
			end else begin
				merged_word[8*j +: 8] = 8'h00;
			end
		end
	end

	always_comb begin
		if (pad_first_q) begin
			pad_word = merged_word;
		end else if ((!long_q || second_q) && pw_q == 4'd14) begin
			pad_word = bit_count_q[31:0];
		end else if ((!long_q || second_q) && pw_q == 4'd15) begin
			pad_word = bit_count_q[63:32];
		end else begin
			pad_word = 32'd0;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = word_pos;
		mem_wdata = {q_out.item.byte_val, acc_q[23:0]};
		if (state_q == ST_IDLE && q_out.valid && q_out.item.has_byte
				&& byte_pos == 2'd3) begin
			mem_we = 1'b1;
		end else if (state_q == ST_PAD) begin
			mem_we    = 1'b1;
			mem_waddr = pw_q;
			mem_wdata = pad_word;
		end
		mem_raddr = (state_q == ST_COMP) ? md5_g(step_q + 6'd1) : 4'd0;
	end

	always_comb begin
		unique case (step_q[5:4])
			2'd0: f_val = (b_q & c_q) | (~b_q & d_q);
			2'd1: f_val = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f_val = b_q ^ c_q ^ d_q;
			default: f_val = c_q ^ (b_q | ~d_q);
		endcase
		t_sum = a_q + f_val + rdata_q + md5_k(step_q);
		rot   = md5_rot(step_q);
		t_rot = (t_sum << rot) | (t_sum >> (6'd32 - {1'b0, rot}));
		t_new = t_rot + b_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			word_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= word_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			chain_q[0]    <= InitA;
			chain_q[1]    <= InitB;
			chain_q[2]    <= InitC;
			chain_q[3]    <= InitD;
			bit_count_q   <= 64'd0;
			acc_q         <= 32'd0;
			a_q           <= 32'd0;
			b_q           <= 32'd0;
			c_q           <= 32'd0;
			d_q           <= 32'd0;
			step_q        <= 6'd0;
			pw_q          <= 4'd0;
			pad_first_q   <= 1'b0;
			long_q        <= 1'b0;
			second_q      <= 1'b0;
			padding_q     <= 1'b0;
			pend_final_q  <= 1'b0;
			emit_k_q      <= 2'd0;
			out_valid_q   <= 1'b0;
			digest_word_q <= 32'd0;
			word_index_q  <= 2'd0;
			last_word_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_out.valid) begin
						if (q_out.item.has_byte) begin
							acc_q[{byte_pos, 3'b000} +: 8] <= q_out.item.byte_val;
							bit_count_q <= bit_count_q + 64'd8;
							if (bit_count_q[8:3] == 6'h3F) begin
								state_q      <= ST_COMP;
								pend_final_q <= q_out.item.is_final;
								a_q          <= chain_q[0];
								b_q          <= chain_q[1];
								c_q          <= chain_q[2];
								d_q          <= chain_q[3];
								step_q       <= 6'd0;
							end else if (q_out.item.is_final) begin
								state_q <= ST_PSTART;
							end
						end else if (q_out.item.is_final) begin
							state_q <= ST_PSTART;
						end
					end
				end
				ST_PSTART: begin
					padding_q   <= 1'b1;
					pad_first_q <= 1'b1;
					pw_q        <= word_pos;
					long_q      <= (word_pos[3:1] == 3'b111);
					second_q    <= 1'b0;
					state_q     <= ST_PAD;
				end
				ST_PAD: begin
					pad_first_q <= 1'b0;
					if (pw_q == 4'd15) begin
						state_q <= ST_COMP;
						a_q     <= chain_q[0];
						b_q     <= chain_q[1];
						c_q     <= chain_q[2];
						d_q     <= chain_q[3];
						step_q  <= 6'd0;
					end else begin
						pw_q <= pw_q + 4'd1;
					end
				end
				ST_COMP: begin
					a_q    <= d_q;
					b_q    <= t_new;
					c_q    <= b_q;
					d_q    <= c_q;
					step_q <= step_q + 6'd1;
					if (step_q == 6'd63) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					if (padding_q) begin
						if (long_q && !second_q) begin
							second_q <= 1'b1;
							pw_q     <= 4'd0;
							state_q  <= ST_PAD;
						end else begin
							emit_k_q <= 2'd0;
							state_q  <= ST_EMIT;
						end
					end else if (pend_final_q) begin
						pend_final_q <= 1'b0;
						state_q      <= ST_PSTART;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						out_valid_q   <= 1'b1;
						digest_word_q <= chain_q[emit_k_q];
						word_index_q  <= emit_k_q;
						last_word_q   <= (emit_k_q == 2'd3);
						emit_k_q      <= emit_k_q + 2'd1;
						if (emit_k_q == 2'd3) begin
							chain_q[0]  <= InitA;
							chain_q[1]  <= InitB;
							chain_q[2]  <= InitC;
							chain_q[3]  <= InitD;
							bit_count_q <= 64'd0;
							padding_q   <= 1'b0;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: sv/md5_message_digest_core.sv
`default_nettype none
// MD5 hash engine taking one message byte per transaction. A four-entry queue
// accepts a transaction every cycle while it has room; the hashing side drains
// one byte per cycle while it is not busy and, after every 64th byte, works on
// the block (64 compression steps on a single shared step unit, then a fold of
// the result into the chaining words). A final transaction starts padding,
// writes the padding words (up to 16, twice when the length no longer fits the
// current block), compresses each padded block, and emits the digest as four
// output transactions, word 0 first, the last one flagged. The engine is then
// ready for the next message.
module md5_message_digest_core import md5_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  msg_byte,
	input  wire logic        byte_present,
	input  wire logic        final_req,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic [1:0]       word_index,
	output logic             last_word
);

	md5_queue_out_t q_out;
	logic           q_pop;

	md5_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.msg_byte     (msg_byte),
		.byte_present (byte_present),
		.final_req    (final_req),
		.q_out        (q_out),
		.q_pop        (q_pop)
	);

	md5_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_out       (q_out),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule
`default_nettype wire

// File: sv/md5_checker.sv
`default_nettype none
module md5_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] digest_word,
	input wire logic [1:0]  word_index,
	input wire logic        last_word
);

	// A stalled output transaction keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word)
			&& $stable(word_index) && $stable(last_word))
		else $error("output payload changed while stalled");

	// Only the fourth digest word carries the last flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 2'd3)))
		else $error("last flag does not match the word index");

	// The digest words of one message follow each other without a gap.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=> out_valid
			&& word_index == 2'($past(word_index) + 2'd1))
		else $error("digest words out of sequence");

	// A digest always starts with its first word.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> word_index == 2'd0)
		else $error("digest started with a later word");

endmodule

bind md5_message_digest_core md5_checker u_md5_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.digest_word  (digest_word),
	.word_index   (word_index),
	.last_word    (last_word)
);
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 180;
	localparam int PAUSE_AT = 2;
	localparam int TRAIL_CYCLES = 300;
	localparam int ROWS = 16;

	localparam logic [0:63][31:0] SINE_TAB = {
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [0:15][4:0] SHIFT_TAB = {
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	localparam logic [0:3][31:0] CHAIN_START = {
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	localparam logic [0:3][31:0] EMPTY_DIGEST = {
		32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec
	};
	localparam logic [0:3][31:0] A_DIGEST = {
		32'hb975c10c, 32'ha8b6f1c0, 32'he299c331, 32'h61267769
	};
	localparam logic [0:3][31:0] ABC_DIGEST = {
		32'h98500190, 32'hb04fd23c, 32'h7d3f96d6, 32'h727fe128
	};
	localparam logic [0:3][31:0] NO_DIGEST = 128'h0;

	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  index;
		logic        last;
	} digest_beat_t;

	typedef struct packed {
		logic [7:0]       data;
		logic             present;
		logic             fin;
		logic             known;
		logic [0:3][31:0] digest;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  msg_byte;
	logic        byte_present;
	logic        final_req;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	logic             row_known;
	logic [0:3][31:0] row_digest;

	logic [0:3][31:0] chain_q;
	logic [7:0]       block_q [64];
	logic [63:0]      bit_len_q;

	digest_beat_t digest_queue [$];
	stim_row_t    stim_table [ROWS];

	int  fail_count = 0;
	int  quiet_cycles = 0;
	int  bytes_hashed = 0;
	int  digests_done = 0;
	int  words_checked = 0;
	int  items_sent = 0;
	int  idle_items = 0;
	int  msgs_sent = 0;
	int  longest_msg = 0;
	logic sender_burst = 1'b0;
	logic hold_req = 1'b0;
	logic hold_started = 1'b0;

	md5_message_digest_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.msg_byte(msg_byte),
		.byte_present(byte_present),
		.final_req(final_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.digest_word(digest_word),
		.word_index(word_index),
		.last_word(last_word)
	);

	always #5 clk = ~clk;

	function automatic void md5_compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, f, t;
		int i, g, s, rnd;
		for (i = 0; i < 16; i++) begin
			w[i] = {block_q[4 * i + 3], block_q[4 * i + 2], block_q[4 * i + 1], block_q[4 * i]};
		end
		a = chain_q[0];
		b = chain_q[1];
		c = chain_q[2];
		d = chain_q[3];
		for (i = 0; i < 64; i++) begin
			rnd = i / 16;
			case (rnd)
				0: begin
					f = (b & c) | (~b & d);
					g = i;
				end
				1: begin
					f = (b & d) | (c & ~d);
					g = (5 * i + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * i + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * i) % 16;
				end
			endcase
			t = a + f + w[g] + SINE_TAB[i];
			s = SHIFT_TAB[rnd * 4 + i % 4];
			t = ((t << s) | (t >> (32 - s))) + b;
			a = d;
			d = c;
			c = b;
			b = t;
		end
		chain_q[0] = chain_q[0] + a;
		chain_q[1] = chain_q[1] + b;
		chain_q[2] = chain_q[2] + c;
		chain_q[3] = chain_q[3] + d;
	endfunction

	function automatic void md5_absorb(input logic [7:0] data);
		int idx;
		idx = int'(bit_len_q[8:3]);
		block_q[idx] = data;
		bit_len_q = bit_len_q + 64'd8;
		if (idx == 63) begin
			md5_compress();
		end
	endfunction

	function automatic void md5_finish(output logic [0:3][31:0] words);
		logic [63:0] len;
		int idx, k;
		len = bit_len_q;
		idx = int'(bit_len_q[8:3]);
		block_q[idx] = 8'h80;
		idx++;
		if (idx == 64) begin
			md5_compress();
			idx = 0;
		end
		if (idx > 56) begin
			while (idx < 64) begin
				block_q[idx] = 8'h00;
				idx++;
			end
			md5_compress();
			idx = 0;
		end
		while (idx < 56) begin
			block_q[idx] = 8'h00;
			idx++;
		end
		for (k = 0; k < 8; k++) begin
			block_q[56 + k] = len[8 * k +: 8];
		end
		md5_compress();
		words = chain_q;
		chain_q = CHAIN_START;
		bit_len_q = 64'd0;
	endfunction

	function automatic void log_failure(input string what);
		fail_count++;
		if (fail_count <= 10) begin
			$display("ERROR at %0t ns: %s", $time, what);
		end
	endfunction

	function automatic int next_gap();
		int r;
		if (sender_burst) begin
			return 0;
		end
		r = $urandom_range(99);
		if (r < 60) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(30, 8);
	endfunction

	always @(posedge clk) begin
		logic [0:3][31:0] words;
		digest_beat_t got, want;
		int k;
		if (arst_n) begin
			if (in_valid && in_ready || out_valid && out_ready) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (out_valid && out_ready) begin
				got = {digest_word, word_index, last_word};
				if (digest_queue.size() == 0) begin
					log_failure($sformatf("unexpected digest word %0d = %08h last %0b",
						word_index, digest_word, last_word));
				end else begin
					want = digest_queue.pop_front();
					words_checked++;
					if (got !== want) begin
						log_failure($sformatf(
							"expected word %0d = %08h last %0b, got word %0d = %08h last %0b",
							want.index, want.word, want.last, got.index, got.word, got.last));
					end
				end
			end
			if (in_valid && in_ready) begin
				if (byte_present) begin
					md5_absorb(msg_byte);
					bytes_hashed++;
				end
				if (final_req) begin
					md5_finish(words);
					if (row_known) begin
						words = row_digest;
					end
					for (k = 0; k < 4; k++) begin
						digest_queue.push_back({words[k], 2'(k), k == 3});
					end
					digests_done++;
				end
			end
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int stall_left, r;
		logic calm;
		stall_left = 0;
		calm = 1'b0;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_started) begin
				hold_started = 1'b1;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if ($urandom_range(99) == 0) begin
				calm = ~calm;
			end
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = 1'b1;
				r = $urandom_range(99);
				if (!calm && r < 20) begin
					stall_left = $urandom_range(3, 1);
				end else if (!calm && r < 25) begin
					stall_left = $urandom_range(40, 10);
				end
			end
		end
	end

	task automatic send_item(input logic [7:0] data, input logic present, input logic fin,
			input logic known, input logic [0:3][31:0] digest, input int gap);
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		msg_byte = data;
		byte_present = present;
		final_req = fin;
		row_known = known;
		row_digest = digest;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_message(input int len, input logic steady);
		int k;
		logic tie;
		tie = len > 0 && $urandom_range(1) == 1;
		sender_burst = steady || $urandom_range(3) == 0;
		for (k = 0; k < len; k++) begin
			if (!steady && $urandom_range(9) == 0) begin
				send_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, NO_DIGEST, next_gap());
				idle_items++;
			end
			send_item(8'($urandom_range(255)), 1'b1, tie && k == len - 1, 1'b0, NO_DIGEST,
				next_gap());
			items_sent++;
		end
		if (!tie) begin
			send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, NO_DIGEST, next_gap());
			items_sent++;
		end
		msgs_sent++;
		if (len > longest_msg) begin
			longest_msg = len;
		end
	endtask

	task automatic wait_for_digests();
		while (digest_queue.size() != 0) @(posedge clk);
	endtask

	function automatic int pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 30) begin
			return $urandom_range(8, 0);
		end
		if (r < 65) begin
			case ($urandom_range(7))
				0: return 55;
				1: return 56;
				2: return 57;
				3: return 63;
				4: return 64;
				5: return 65;
				6: return 119;
				default: return 120;
			endcase
		end
		return $urandom_range(130, 0);
	endfunction

	initial begin
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		msg_byte = 8'h00;
		byte_present = 1'b0;
		final_req = 1'b0;
		row_known = 1'b0;
		row_digest = NO_DIGEST;
		chain_q = CHAIN_START;
		bit_len_q = 64'd0;
		for (i = 0; i < 64; i++) begin
			block_q[i] = 8'h00;
		end

		// Known digests of the empty message, "a" and "abc", with an ignored
		// transaction in the middle of "abc"; the remaining rows are predicted.
		stim_table[0]  = {8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST};
		stim_table[1]  = {8'h61, 1'b1, 1'b1, 1'b1, A_DIGEST};
		stim_table[2]  = {8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST};
		stim_table[3]  = {8'hff, 1'b0, 1'b0, 1'b0, NO_DIGEST};
		stim_table[4]  = {8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST};
		stim_table[5]  = {8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST};
		stim_table[6]  = {8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST};
		stim_table[7]  = {8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST};
		stim_table[8]  = {8'hff, 1'b1, 1'b0, 1'b0, NO_DIGEST};
		stim_table[9]  = {8'hff, 1'b0, 1'b1, 1'b0, NO_DIGEST};
		stim_table[10] = {8'hff, 1'b1, 1'b1, 1'b0, NO_DIGEST};
		stim_table[11] = {8'h80, 1'b1, 1'b0, 1'b0, NO_DIGEST};
		stim_table[12] = {8'h7f, 1'b1, 1'b0, 1'b0, NO_DIGEST};
		stim_table[13] = {8'h55, 1'b1, 1'b0, 1'b0, NO_DIGEST};
		stim_table[14] = {8'haa, 1'b1, 1'b0, 1'b0, NO_DIGEST};
		stim_table[15] = {8'h01, 1'b1, 1'b1, 1'b0, NO_DIGEST};

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < ROWS; i++) begin
			send_item(stim_table[i].data, stim_table[i].present, stim_table[i].fin,
				stim_table[i].known, stim_table[i].digest, next_gap());
		end
		@(negedge clk);
		in_valid = 1'b0;
		wait_for_digests();

		// The receiver is held off while short messages keep arriving, so that
		// the engine and its input queue back up.
		hold_req = 1'b1;
		while (!hold_started) @(negedge clk);
		for (i = 0; i < 4; i++) begin
			send_message(2, 1'b1);
		end

		items_sent = 0;
		i = 0;
		while (items_sent < RANDOM_ITEMS) begin
			send_message(pick_length(), 1'b0);
			i++;
			if (i == PAUSE_AT) begin
				@(negedge clk);
				in_valid = 1'b0;
				wait_for_digests();
			end
		end
		@(negedge clk);
		in_valid = 1'b0;
		wait_for_digests();
		repeat (TRAIL_CYCLES) @(posedge clk);

		$display("Hashed %0d messages (%0d bytes, longest %0d) plus %0d ignored transactions,",
			digests_done, bytes_hashed, longest_msg, idle_items);
		$display("checked %0d digest words with %0d failures.", words_checked, fail_count);
		if (fail_count == 0 && digest_queue.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
`default_nettype wire
